// File: src/encoder_wheel_velocity_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the encoder wheel velocity core
// Shared property templates, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ENCODER_WHEEL_VELOCITY_CORE_ASSERT_SVH
`define ENCODER_WHEEL_VELOCITY_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EWV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("ewv: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EWV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("ewv: next-cycle check failed");

`endif

// File: src/ewv_pkg.sv
// ----------------------------------------------------------------------------
// ewv_pkg
// Types, widths and codes shared by the encoder wheel velocity modules.
// ----------------------------------------------------------------------------
package ewv_pkg;

    localparam int COUNT_W   = 16;
    localparam int DIST_W    = 24;
    localparam int IVL_W     = 16;
    localparam int NUM_W     = COUNT_W + DIST_W;
    localparam int DEN_W     = COUNT_W + IVL_W;
    localparam int VEL_W     = NUM_W + 1;
    localparam int STATUS_W  = 2;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = DIST_W;

    localparam logic [COUNT_W-1:0] CPR_RESET  = COUNT_W'(1560);
    localparam logic [DIST_W-1:0]  DPR_RESET  = DIST_W'(52276);

    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_PER_REV = 1'b1;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED    = 2'd0,
        ST_DIR_CHANGE = 2'd1,
        ST_ZERO_IVL   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_SIGN,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic prep;
        logic mul;
        logic div_step;
        logic sign;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic updated;
        logic out_free;
    } t_sts;

endpackage

// File: src/ewv_ctrl.sv
// ----------------------------------------------------------------------------
// ewv_ctrl
// Sequencer for one sample: capture, prepare, then multiply, divide and sign for an updated sample, output.
// ----------------------------------------------------------------------------
module ewv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ewv_pkg::t_sts i_sts,
    output ewv_pkg::t_cmd o_cmd
);
    import ewv_pkg::*;

    `include "encoder_wheel_velocity_core_assert.svh"

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_sts.updated ? S_MUL : S_OUT;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                o_cmd.sign = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                // Wait until the output register is empty or being emptied.
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `EWV_ASSERT_NEXT(a_accept_to_prep, i_valid && o_ready, r_state == S_PREP)
    `EWV_ASSERT_NEXT(a_held_skips_div, r_state == S_PREP && !i_sts.updated, r_state == S_OUT)
    `EWV_ASSERT_NEXT(a_div_runs_on, r_state == S_DIV && r_cnt != LAST_STEP, r_state == S_DIV)

endmodule

// File: src/ewv_datapath.sv
// ----------------------------------------------------------------------------
// ewv_datapath
// Configuration, sample state, delta, products, restoring divider and output.
// ----------------------------------------------------------------------------
module ewv_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ewv_pkg::t_cmd                     i_cmd,
    output ewv_pkg::t_sts                     o_sts,
    input  logic                              i_cfg_we,
    input  logic [ewv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ewv_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [ewv_pkg::COUNT_W-1:0]       i_position_count,
    input  logic                              i_count_down,
    input  logic [ewv_pkg::IVL_W-1:0]         i_interval,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [ewv_pkg::VEL_W-1:0]  o_velocity,
    output logic [ewv_pkg::STATUS_W-1:0]      o_status
);
    import ewv_pkg::*;

    `include "encoder_wheel_velocity_core_assert.svh"

    // Configuration registers.
    logic [COUNT_W-1:0] r_cpr;
    logic [DIST_W-1:0]  r_dpr;

    // Captured sample.
    logic [COUNT_W-1:0] r_pos;
    logic               r_down;
    logic [IVL_W-1:0]   r_ivl;

    // State carried between samples.
    logic [COUNT_W-1:0] r_last_count;
    t_dir               r_last_dir;
    logic [VEL_W-1:0]   r_held;

    // Working registers.
    logic [COUNT_W-1:0] r_mod;
    logic [COUNT_W-1:0] r_delta;
    t_status            r_status;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;

    // Output register.
    logic               r_out_valid;
    logic [VEL_W-1:0]   r_out_vel;
    t_status            r_out_status;

    logic [COUNT_W-1:0] n_mod, n_mod_m1, n_cur, n_prev, n_delta;
    logic [COUNT_W:0]   n_wrap_up, n_wrap_dn;
    t_dir               n_dir;
    t_status            n_status;
    logic [DEN_W:0]     n_trial, n_diff;
    logic               n_ge;
    logic [NUM_W-1:0]   n_prod;
    logic [DEN_W-1:0]   n_den;

    // A zero modulus behaves as one; counts at or above it are clamped.
    always_comb begin
        n_mod     = (r_cpr == '0) ? COUNT_W'(1) : r_cpr;
        n_mod_m1  = n_mod - 1'b1;
        n_cur     = (r_pos >= n_mod) ? n_mod_m1 : r_pos;
        n_prev    = (r_last_count >= n_mod) ? n_mod_m1 : r_last_count;
        n_dir     = r_down ? DIR_DOWN : DIR_UP;
        n_wrap_up = {1'b0, n_cur} + {1'b0, n_mod} - {1'b0, n_prev};
        n_wrap_dn = {1'b0, n_prev} + {1'b0, n_mod} - {1'b0, n_cur};
        if (n_dir == DIR_UP) begin
            n_delta = (n_cur < n_prev) ? n_wrap_up[COUNT_W-1:0] : (n_cur - n_prev);
        end else begin
            n_delta = (n_cur > n_prev) ? n_wrap_dn[COUNT_W-1:0] : (n_prev - n_cur);
        end
        // A direction change is checked before the interval.
        if (n_dir != r_last_dir) begin
            n_status = ST_DIR_CHANGE;
        end else if (r_ivl == '0) begin
            n_status = ST_ZERO_IVL;
        end else begin
            n_status = ST_UPDATED;
        end
    end

    assign n_prod = r_dpr * r_delta;
    assign n_den  = r_mod * r_ivl;

    // One quotient bit per step of the restoring divider.
    assign n_trial = {r_rem, r_num[NUM_W-1]};
    assign n_ge    = (n_trial >= {1'b0, r_den});
    assign n_diff  = n_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr        <= CPR_RESET;
            r_dpr        <= DPR_RESET;
            r_last_count <= '0;
            r_last_dir   <= DIR_NONE;
            r_held       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_COUNTS_PER_REV:   r_cpr <= i_cfg_data[COUNT_W-1:0];
                    REG_DISTANCE_PER_REV: r_dpr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.prep) begin
                r_last_count <= n_cur;
                r_last_dir   <= n_dir;
            end
            if (i_cmd.sign) begin
                r_held <= r_down ? (VEL_W'(0) - {1'b0, r_num}) : {1'b0, r_num};
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pos  <= i_position_count;
            r_down <= i_count_down;
            r_ivl  <= i_interval;
        end
        if (i_cmd.prep) begin
            r_mod    <= n_mod;
            r_delta  <= n_delta;
            r_status <= n_status;
        end
        if (i_cmd.mul) begin
            r_num <= n_prod;
            r_den <= n_den;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_ge ? n_diff[DEN_W-1:0] : n_trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], n_ge};
        end
        if (i_cmd.load_out) begin
            r_out_vel    <= r_held;
            r_out_status <= r_status;
        end
    end

    assign o_sts.updated  = (n_status == ST_UPDATED);
    assign o_sts.out_free = !r_out_valid || i_ready;

    assign o_valid    = r_out_valid;
    assign o_velocity = r_out_vel;
    assign o_status   = r_out_status;

    `EWV_ASSERT_SAME(a_rem_below_den, i_cmd.div_step, r_rem < r_den)
    `EWV_ASSERT_NEXT(a_down_not_positive, i_cmd.sign && r_down, r_held[VEL_W-1] || r_held == '0)
    `EWV_ASSERT_NEXT(a_out_held, r_out_valid && !i_ready, r_out_valid && $stable(r_out_vel))

endmodule

// File: src/encoder_wheel_velocity_core.sv
// ----------------------------------------------------------------------------
// encoder_wheel_velocity_core
// Wheel velocity from successive samples of a wrapping quadrature counter.
// ----------------------------------------------------------------------------
// Each accepted sample yields exactly one result. A sample whose direction
// differs from the previous one (and the first sample after reset), or whose
// interval is zero, returns the held velocity with a nonzero status: one
// state wraps the count delta and decides the status, the next loads the
// output register. An updated velocity passes through the states that wrap
// the count delta, form the two products, run the one-bit-per-cycle
// restoring divider, which sets the rate, apply the sign and load the output
// register. A new sample is taken from the cycle after the previous one has
// been handed to the output register, which may still be waiting for its
// transfer, so the block never takes a sample while one is in progress.
// Configuration writes are always accepted and must only be made while the
// block is idle.
module encoder_wheel_velocity_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ewv_pkg::COUNT_W-1:0]       i_position_count,
    input  logic                              i_count_down,
    input  logic [ewv_pkg::IVL_W-1:0]         i_interval,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [ewv_pkg::VEL_W-1:0]  o_velocity,
    output logic [ewv_pkg::STATUS_W-1:0]      o_status,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ewv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ewv_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ewv_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ewv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ewv_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_position_count (i_position_count),
        .i_count_down     (i_count_down),
        .i_interval       (i_interval),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_velocity       (o_velocity),
        .o_status         (o_status)
    );

endmodule
